// ===== hdl/ldp_pkg.sv =====
// Shared types, constants and saturating add for the lens distortion projection core.
`default_nettype none
package ldp_pkg;

   localparam logic signed [63:0] QLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ONE_Q28 = 64'sh0000_0000_1000_0000;
   localparam logic [31:0] NEG_ONE_Q16 = 32'hFFFF_0000;
   localparam int unsigned DIV_STEPS = 60;

   typedef enum logic [2:0] {
      CSR_FOCAL_LENGTHS    = 3'd0,
      CSR_PRINCIPAL_POINT  = 3'd1,
      CSR_RADIAL_ONE       = 3'd2,
      CSR_RADIAL_TWO       = 3'd3,
      CSR_TANGENTIAL_ONE   = 3'd4,
      CSR_TANGENTIAL_TWO   = 3'd5,
      CSR_TAN_SCALE_TWO    = 3'd6,
      CSR_TAN_SCALE_FOUR   = 3'd7
   } ldp_csr_type;

   typedef struct packed {
      logic valid;
      logic behind;
      logic sat;
   } ldp_ctl_type;

   typedef struct packed {
      logic               flag;
      logic signed [63:0] val;
   } ldp_sum_type;

   // operands stay within +-QLIM, so the raw sum cannot wrap
   function automatic ldp_sum_type ldp_sadd(input logic signed [63:0] x,
                                            input logic signed [63:0] y);
      ldp_sum_type        r;
      logic signed [63:0] s;
      s = x + y;
      r.flag = 1'b0;
      r.val  = s;
      if (s > QLIM) begin
         r.flag = 1'b1;
         r.val  = QLIM;
      end else if (s < -QLIM) begin
         r.flag = 1'b1;
         r.val  = -QLIM;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ldp_div.sv =====
// Pipelined restoring divider: a = x * 2^28 / z and b = y * 2^28 / z, one quotient bit per stage.
`default_nettype none
module ldp_div
   import ldp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] in_x,
   input  wire logic signed [31:0] in_y,
   input  wire logic signed [31:0] in_z,
   output logic signed [63:0]      out_a,
   output logic signed [63:0]      out_b,
   output ldp_ctl_type             out_ctl
);

   logic [31:0]           rem_ff [2][0:DIV_STEPS];
   logic [DIV_STEPS-1:0]  num_ff [2][0:DIV_STEPS];
   logic [30:0]           den_ff [0:DIV_STEPS];
   logic                  neg_ff [2][0:DIV_STEPS];
   ldp_ctl_type           ctl_ff [0:DIV_STEPS];
   logic signed [63:0]    a_ff;
   logic signed [63:0]    b_ff;
   ldp_ctl_type           out_ctl_ff;

   logic [31:0] mag_x;
   logic [31:0] mag_y;
   logic        behind;

   assign mag_x  = in_x[31] ? 32'(-in_x) : 32'(in_x);
   assign mag_y  = in_y[31] ? 32'(-in_y) : 32'(in_y);
   assign behind = in_z[31] | (in_z == 32'sd0);

   always_ff @(posedge clock) begin
      rem_ff[0][0] <= '0;
      rem_ff[1][0] <= '0;
      num_ff[0][0] <= {mag_x, 28'd0};
      num_ff[1][0] <= {mag_y, 28'd0};
      neg_ff[0][0] <= in_x[31];
      neg_ff[1][0] <= in_y[31];
      // a behind point divides by one; its quotient is dropped at the output
      den_ff[0]    <= behind ? 31'd1 : in_z[30:0];
      ctl_ff[0]    <= '{valid: in_valid & ~reset, behind: behind, sat: 1'b0};
   end

   for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [31:0] trial;
         logic        ge;
         assign trial = {rem_ff[l][i-1][30:0], num_ff[l][i-1][DIV_STEPS-1]};
         assign ge    = trial >= {1'b0, den_ff[i-1]};
         always_ff @(posedge clock) begin
            rem_ff[l][i] <= ge ? trial - {1'b0, den_ff[i-1]} : trial;
            num_ff[l][i] <= {num_ff[l][i-1][DIV_STEPS-2:0], ge};
            neg_ff[l][i] <= neg_ff[l][i-1];
         end
      end
      always_ff @(posedge clock) begin
         den_ff[i] <= den_ff[i-1];
         ctl_ff[i] <= '{valid: ctl_ff[i-1].valid & ~reset, behind: ctl_ff[i-1].behind,
                        sat: ctl_ff[i-1].sat};
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= neg_ff[0][DIV_STEPS] ? -64'(num_ff[0][DIV_STEPS]) : 64'(num_ff[0][DIV_STEPS]);
      b_ff <= neg_ff[1][DIV_STEPS] ? -64'(num_ff[1][DIV_STEPS]) : 64'(num_ff[1][DIV_STEPS]);
      out_ctl_ff <= '{valid: ctl_ff[DIV_STEPS].valid & ~reset,
                      behind: ctl_ff[DIV_STEPS].behind, sat: ctl_ff[DIV_STEPS].sat};
   end

   assign out_a   = a_ff;
   assign out_b   = b_ff;
   assign out_ctl = out_ctl_ff;

endmodule
`default_nettype wire

// ===== hdl/ldp_mul.sv =====
// Six-stage saturating signed multiplier: (a * b) >> SH toward zero, clamped to +-QLIM.
`default_nettype none
module ldp_mul
   import ldp_pkg::*;
#(
   parameter int unsigned SH = 28
)
(
   input  wire logic               clock,
   input  wire logic signed [63:0] in_a,
   input  wire logic signed [63:0] in_b,
   output logic signed [63:0]      out_p,
   output logic                    out_flag
);

   logic [63:0]  ua_ff;
   logic [63:0]  ub_ff;
   logic         neg_ff [1:5];
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [33:0]  mid_ff;
   logic [63:0]  hs_ff;
   logic [31:0]  lolo_ff;
   logic [63:0]  hi_ff;
   logic [63:0]  lo_ff;
   logic [63:0]  mag_ff;
   logic         ovf_ff [5:6];
   logic signed [63:0] p_ff;

   logic [127:0] shifted;
   logic         ovf;

   assign shifted = {hi_ff, lo_ff} >> SH;
   assign ovf     = (|shifted[127:64]) || (shifted[63:0] > QLIM);

   always_ff @(posedge clock) begin
      ua_ff     <= in_a[63] ? 64'(-in_a) : 64'(in_a);
      ub_ff     <= in_b[63] ? 64'(-in_b) : 64'(in_b);
      neg_ff[1] <= in_a[63] != in_b[63];
      for (int i = 2; i <= 5; i++) begin
         neg_ff[i] <= neg_ff[i-1];
      end

      p00_ff <= 64'(ua_ff[31:0])  * 64'(ub_ff[31:0]);
      p01_ff <= 64'(ua_ff[31:0])  * 64'(ub_ff[63:32]);
      p10_ff <= 64'(ua_ff[63:32]) * 64'(ub_ff[31:0]);
      p11_ff <= 64'(ua_ff[63:32]) * 64'(ub_ff[63:32]);

      mid_ff  <= 34'(p00_ff[63:32]) + 34'(p01_ff[31:0]) + 34'(p10_ff[31:0]);
      hs_ff   <= p11_ff + 64'(p01_ff[63:32]) + 64'(p10_ff[63:32]);
      lolo_ff <= p00_ff[31:0];

      hi_ff <= hs_ff + 64'(mid_ff[33:32]);
      lo_ff <= {mid_ff[31:0], lolo_ff};

      mag_ff    <= ovf ? 64'(QLIM) : shifted[63:0];
      ovf_ff[5] <= ovf;

      p_ff      <= neg_ff[5] ? -signed'(mag_ff) : signed'(mag_ff);
      ovf_ff[6] <= ovf_ff[5];
   end

   assign out_p    = p_ff;
   assign out_flag = ovf_ff[6];

endmodule
`default_nettype wire

// ===== hdl/lens_distortion_projection_core.sv =====
// Top level: camera point to distorted pixel projection, fully pipelined.
// An accepted start passes the divider and then ctl_ff[1..LAST] to the rsp_valid strobe.
// Throughput: one transaction per cycle while busy is low; depth is set by
// the 60 one-bit divider stages, then five chained multiplier levels and the add stages.
// Reset clears every valid bit and all configuration registers; busy is high
// during reset and for the cycle after it. Results cannot be stalled.
`default_nettype none
module lens_distortion_projection_core
   import ldp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_depth,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_pixel_u,
   output logic signed [31:0]      rsp_pixel_v,
   output logic                    rsp_behind_camera,
   output logic                    rsp_saturated,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);

   localparam int LATENCY = 100;
   localparam int LAST    = 38;

   // configuration
   logic [63:0] focal_ff;
   logic [63:0] center_ff;
   logic [31:0] k1_ff, k2_ff, p1_ff, p2_ff, p3_ff, p4_ff;
   logic        busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         focal_ff  <= '0;
         center_ff <= '0;
         k1_ff     <= '0;
         k2_ff     <= '0;
         p1_ff     <= '0;
         p2_ff     <= '0;
         p3_ff     <= '0;
         p4_ff     <= '0;
      end else if (csr_we) begin
         case (ldp_csr_type'(csr_index))
            CSR_FOCAL_LENGTHS:   focal_ff  <= csr_wdata;
            CSR_PRINCIPAL_POINT: center_ff <= csr_wdata;
            CSR_RADIAL_ONE:      k1_ff     <= csr_wdata[31:0];
            CSR_RADIAL_TWO:      k2_ff     <= csr_wdata[31:0];
            CSR_TANGENTIAL_ONE:  p1_ff     <= csr_wdata[31:0];
            CSR_TANGENTIAL_TWO:  p2_ff     <= csr_wdata[31:0];
            CSR_TAN_SCALE_TWO:   p3_ff     <= csr_wdata[31:0];
            CSR_TAN_SCALE_FOUR:  p4_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign busy = busy_ff;

   logic signed [63:0] k1, k2, p1, p2, p3, p4, p1x2, p2x2, fx, fy, cx, cy;
   assign k1   = {{32{k1_ff[31]}}, k1_ff};
   assign k2   = {{32{k2_ff[31]}}, k2_ff};
   assign p1   = {{32{p1_ff[31]}}, p1_ff};
   assign p2   = {{32{p2_ff[31]}}, p2_ff};
   assign p3   = {{32{p3_ff[31]}}, p3_ff};
   assign p4   = {{32{p4_ff[31]}}, p4_ff};
   // doubled 32-bit coefficients never reach the clamp
   assign p1x2 = {{31{p1_ff[31]}}, p1_ff, 1'b0};
   assign p2x2 = {{31{p2_ff[31]}}, p2_ff, 1'b0};
   assign fx   = {32'd0, focal_ff[63:32]};
   assign fy   = {32'd0, focal_ff[31:0]};
   assign cx   = {36'd0, center_ff[63:36]};
   assign cy   = {36'd0, center_ff[31:4]};

   // stage 0: normalized coordinates
   logic signed [63:0] div_a, div_b;
   ldp_ctl_type        div_ctl;

   ldp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_valid(start && !busy_ff),
      .in_x    (req_point_x),
      .in_y    (req_point_y),
      .in_z    (req_point_depth),
      .out_a   (div_a),
      .out_b   (div_b),
      .out_ctl (div_ctl)
   );

   logic signed [63:0] a_dly_ff [1:23];
   logic signed [63:0] b_dly_ff [1:23];

   // stage 6
   logic signed [63:0] aa, bb, ab;
   logic               f_aa, f_bb, f_ab;
   ldp_mul u_mul_aa (.clock(clock), .in_a(div_a), .in_b(div_a), .out_p(aa), .out_flag(f_aa));
   ldp_mul u_mul_bb (.clock(clock), .in_a(div_b), .in_b(div_b), .out_p(bb), .out_flag(f_bb));
   ldp_mul u_mul_ab (.clock(clock), .in_a(div_a), .in_b(div_b), .out_p(ab), .out_flag(f_ab));

   ldp_sum_type r2_c, s2a_c, s2b_c;
   logic signed [63:0] r2_ff, s2a_ff, s2b_ff, ab7_ff;

   // stage 7 -> 8
   ldp_sum_type u_c, w_c;
   logic signed [63:0] u_ff, w_ff, r2d_ff, ab8_ff;

   // stage 14
   logic signed [63:0] r4, k1r2, p3r2, p1u, p2w, p2ab, p1ab;
   logic f_r4, f_k1r2, f_p3r2, f_p1u, f_p2w, f_p2ab, f_p1ab;
   ldp_mul u_mul_r4   (.clock(clock), .in_a(r2d_ff), .in_b(r2d_ff), .out_p(r4),
                       .out_flag(f_r4));
   ldp_mul u_mul_k1r2 (.clock(clock), .in_a(k1), .in_b(r2d_ff), .out_p(k1r2),
                       .out_flag(f_k1r2));
   ldp_mul u_mul_p3r2 (.clock(clock), .in_a(p3), .in_b(r2d_ff), .out_p(p3r2),
                       .out_flag(f_p3r2));
   ldp_mul u_mul_p1u  (.clock(clock), .in_a(p1), .in_b(u_ff), .out_p(p1u),
                       .out_flag(f_p1u));
   ldp_mul u_mul_p2w  (.clock(clock), .in_a(p2), .in_b(w_ff), .out_p(p2w),
                       .out_flag(f_p2w));
   ldp_mul u_mul_p2ab (.clock(clock), .in_a(p2x2), .in_b(ab8_ff), .out_p(p2ab),
                       .out_flag(f_p2ab));
   ldp_mul u_mul_p1ab (.clock(clock), .in_a(p1x2), .in_b(ab8_ff), .out_p(p1ab),
                       .out_flag(f_p1ab));

   ldp_sum_type tx_c, ty_c;
   logic signed [63:0] tx_dly_ff [15:23];
   logic signed [63:0] ty_dly_ff [15:23];
   logic signed [63:0] r4d_ff;
   logic signed [63:0] k1r2_dly_ff [15:21];
   logic signed [63:0] p3r2_dly_ff [15:21];

   // stage 21
   logic signed [63:0] k2r4, p4r4;
   logic               f_k2r4, f_p4r4;
   ldp_mul u_mul_k2r4 (.clock(clock), .in_a(k2), .in_b(r4d_ff), .out_p(k2r4),
                       .out_flag(f_k2r4));
   ldp_mul u_mul_p4r4 (.clock(clock), .in_a(p4), .in_b(r4d_ff), .out_p(p4r4),
                       .out_flag(f_p4r4));

   ldp_sum_type rad_c, sp_c, scale_c;
   logic signed [63:0] rad_ff [22:23];
   logic signed [63:0] sp_ff;
   logic signed [63:0] scale_ff;

   // stage 29
   logic signed [63:0] arad, brad, txs, tys;
   logic               f_arad, f_brad, f_txs, f_tys;
   ldp_mul u_mul_arad (.clock(clock), .in_a(a_dly_ff[23]), .in_b(rad_ff[23]),
                       .out_p(arad), .out_flag(f_arad));
   ldp_mul u_mul_brad (.clock(clock), .in_a(b_dly_ff[23]), .in_b(rad_ff[23]),
                       .out_p(brad), .out_flag(f_brad));
   ldp_mul u_mul_txs  (.clock(clock), .in_a(tx_dly_ff[23]), .in_b(scale_ff),
                       .out_p(txs), .out_flag(f_txs));
   ldp_mul u_mul_tys  (.clock(clock), .in_a(ty_dly_ff[23]), .in_b(scale_ff),
                       .out_p(tys), .out_flag(f_tys));

   ldp_sum_type xs_c, ys_c, xd_c, yd_c;
   logic signed [63:0] xs_ff, ys_ff, txs_ff, tys_ff, xd_ff, yd_ff;

   // stage 37: focal scaling to Q16
   logic signed [63:0] fxxd, fyyd;
   logic               f_fxxd, f_fyyd;
   ldp_mul #(.SH(32)) u_mul_fx (.clock(clock), .in_a(fx), .in_b(xd_ff), .out_p(fxxd),
                                .out_flag(f_fxxd));
   ldp_mul #(.SH(32)) u_mul_fy (.clock(clock), .in_a(fy), .in_b(yd_ff), .out_p(fyyd),
                                .out_flag(f_fyyd));

   logic signed [63:0] sum_u, sum_v;
   logic signed [31:0] pix_u_c, pix_v_c;
   logic               clip_u, clip_v;
   logic signed [31:0] pix_u_ff, pix_v_ff;

   assign sum_u = fxxd + cx;
   assign sum_v = fyyd + cy;

   always_comb begin
      clip_u  = 1'b1;
      clip_v  = 1'b1;
      pix_u_c = 32'sh7FFF_FFFF;
      pix_v_c = 32'sh7FFF_FFFF;
      if (sum_u < -64'sd2147483648) begin
         pix_u_c = 32'sh8000_0000;
      end else if (sum_u <= 64'sd2147483647) begin
         pix_u_c = sum_u[31:0];
         clip_u  = 1'b0;
      end
      if (sum_v < -64'sd2147483648) begin
         pix_v_c = 32'sh8000_0000;
      end else if (sum_v <= 64'sd2147483647) begin
         pix_v_c = sum_v[31:0];
         clip_v  = 1'b0;
      end
   end

   always_comb begin
      r2_c    = ldp_sadd(aa, bb);
      s2a_c   = ldp_sadd(aa, aa);
      s2b_c   = ldp_sadd(bb, bb);
      u_c     = ldp_sadd(r2_ff, s2a_ff);
      w_c     = ldp_sadd(r2_ff, s2b_ff);
      tx_c    = ldp_sadd(p1u, p2ab);
      ty_c    = ldp_sadd(p1ab, p2w);
      rad_c   = ldp_sadd(k1r2_dly_ff[21], k2r4);
      sp_c    = ldp_sadd(p3r2_dly_ff[21], p4r4);
      scale_c = ldp_sadd(ONE_Q28, sp_ff);
      xs_c    = ldp_sadd(arad, 64'sd0);
      ys_c    = ldp_sadd(brad, 64'sd0);
      xd_c    = ldp_sadd(xs_ff, txs_ff);
      yd_c    = ldp_sadd(ys_ff, tys_ff);
   end

   // a and b reach stage 29 through the tail of their delay lines
   logic signed [63:0] a_tail_ff [24:29];
   logic signed [63:0] b_tail_ff [24:29];
   ldp_sum_type        xa_c, yb_c;
   assign xa_c = ldp_sadd(a_tail_ff[29], xs_c.val);
   assign yb_c = ldp_sadd(b_tail_ff[29], ys_c.val);

   always_ff @(posedge clock) begin
      a_dly_ff[1] <= div_a;
      b_dly_ff[1] <= div_b;
      for (int i = 2; i <= 23; i++) begin
         a_dly_ff[i] <= a_dly_ff[i-1];
         b_dly_ff[i] <= b_dly_ff[i-1];
      end
      a_tail_ff[24] <= a_dly_ff[23];
      b_tail_ff[24] <= b_dly_ff[23];
      for (int i = 25; i <= 29; i++) begin
         a_tail_ff[i] <= a_tail_ff[i-1];
         b_tail_ff[i] <= b_tail_ff[i-1];
      end

      r2_ff  <= r2_c.val;
      s2a_ff <= s2a_c.val;
      s2b_ff <= s2b_c.val;
      ab7_ff <= ab;

      u_ff   <= u_c.val;
      w_ff   <= w_c.val;
      r2d_ff <= r2_ff;
      ab8_ff <= ab7_ff;

      tx_dly_ff[15]   <= tx_c.val;
      ty_dly_ff[15]   <= ty_c.val;
      r4d_ff          <= r4;
      k1r2_dly_ff[15] <= k1r2;
      p3r2_dly_ff[15] <= p3r2;
      for (int i = 16; i <= 21; i++) begin
         k1r2_dly_ff[i] <= k1r2_dly_ff[i-1];
         p3r2_dly_ff[i] <= p3r2_dly_ff[i-1];
      end
      for (int i = 16; i <= 23; i++) begin
         tx_dly_ff[i] <= tx_dly_ff[i-1];
         ty_dly_ff[i] <= ty_dly_ff[i-1];
      end

      rad_ff[22] <= rad_c.val;
      sp_ff      <= sp_c.val;
      rad_ff[23] <= rad_ff[22];
      scale_ff   <= scale_c.val;

      xs_ff  <= xa_c.val;
      ys_ff  <= yb_c.val;
      txs_ff <= txs;
      tys_ff <= tys;

      xd_ff <= xd_c.val;
      yd_ff <= yd_c.val;
   end

   // saturation events, indexed by the stage whose values raise them
   logic [LAST-1:1] hit;
   always_comb begin
      hit     = '0;
      hit[6]  = f_aa | f_bb | f_ab | r2_c.flag | s2a_c.flag | s2b_c.flag;
      hit[7]  = u_c.flag | w_c.flag;
      hit[14] = f_r4 | f_k1r2 | f_p3r2 | f_p1u | f_p2w | f_p2ab | f_p1ab
              | tx_c.flag | ty_c.flag;
      hit[21] = f_k2r4 | f_p4r4 | rad_c.flag | sp_c.flag;
      hit[22] = scale_c.flag;
      hit[29] = f_arad | f_brad | f_txs | f_tys | xs_c.flag | ys_c.flag
              | xa_c.flag | yb_c.flag;
      hit[30] = xd_c.flag | yd_c.flag;
      hit[37] = f_fxxd | f_fyyd | clip_u | clip_v;
   end

   ldp_ctl_type ctl_ff [1:LAST];

   always_ff @(posedge clock) begin
      ctl_ff[1] <= '{valid: div_ctl.valid & ~reset, behind: div_ctl.behind,
                     sat: div_ctl.sat};
      for (int t = 2; t <= LAST; t++) begin
         ctl_ff[t] <= '{valid: ctl_ff[t-1].valid & ~reset, behind: ctl_ff[t-1].behind,
                        sat: ctl_ff[t-1].sat | hit[t-1]};
      end
   end

   always_ff @(posedge clock) begin
      pix_u_ff <= ctl_ff[LAST-1].behind ? signed'(NEG_ONE_Q16) : pix_u_c;
      pix_v_ff <= ctl_ff[LAST-1].behind ? signed'(NEG_ONE_Q16) : pix_v_c;
   end

   assign rsp_valid         = ctl_ff[LAST].valid;
   assign rsp_pixel_u       = pix_u_ff;
   assign rsp_pixel_v       = pix_v_ff;
   assign rsp_behind_camera = ctl_ff[LAST].behind;
   assign rsp_saturated     = ctl_ff[LAST].sat & ~ctl_ff[LAST].behind;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result at the expected cycle");

   a_behind_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_behind_camera) |->
         (rsp_pixel_u == signed'(NEG_ONE_Q16) && rsp_pixel_v == signed'(NEG_ONE_Q16)
          && !rsp_saturated))
      else $error("behind-camera result carries wrong pixel or saturation");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset, LATENCY)) |-> $past(start && !busy, LATENCY))
      else $error("result without a matching accepted transaction");

endmodule
`default_nettype wire
